### hdl/led_breath_and_color_fade_pwm_unit_macros.svh
// ----------------------------------------------------------------------------
// led_breath_and_color_fade_pwm_unit_macros
// Assertion macros shared by the LED PWM unit.
// ----------------------------------------------------------------------------
`ifndef LED_BREATH_AND_COLOR_FADE_PWM_UNIT_MACROS_SVH
`define LED_BREATH_AND_COLOR_FADE_PWM_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LBCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lbcf: assertion failed");

// Next-cycle implication, disabled during reset.
`define LBCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lbcf: assertion failed");

`endif

### hdl/lbcf_pkg.sv
// ----------------------------------------------------------------------------
// lbcf_pkg
// Types and constants of the LED breathing / color fade PWM unit.
// ----------------------------------------------------------------------------
package lbcf_pkg;

  localparam int CNT_W = 8;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_BREATH = 2'd1;
  localparam logic [1:0] MODE_FADE   = 2'd2;

  localparam logic [1:0] PAIR_RG    = 2'd0;
  localparam logic [1:0] PAIR_GB    = 2'd1;
  localparam logic [1:0] PAIR_BR    = 2'd2;
  localparam logic [1:0] PAIR_SPARE = 2'd3;

  localparam logic [1:0] CFG_PERIOD = 2'd0;
  localparam logic [1:0] CFG_FLOOR  = 2'd1;
  localparam logic [1:0] CFG_ANODE  = 2'd2;

  localparam logic [7:0] PERIOD_RST = 8'd200;
  localparam logic [7:0] FLOOR_RST  = 8'd75;
  localparam logic       ANODE_RST  = 1'b1;

  typedef struct packed {
    logic [7:0] pwm_period;
    logic [7:0] breath_floor;
    logic       common_anode;
  } cfg_t;

  typedef struct packed {
    logic [1:0] requested_mode;
    logic       playing;
  } item_t;

  typedef struct packed {
    logic blue;
    logic green;
    logic red;
    logic power;
  } pins_t;

endpackage

### hdl/lbcf_core.sv
// ----------------------------------------------------------------------------
// lbcf_core
// Mode, PWM counter, duty ramp and pin level state; one update per item.
// ----------------------------------------------------------------------------
`include "led_breath_and_color_fade_pwm_unit_macros.svh"

module lbcf_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  lbcf_pkg::item_t item,
  input  lbcf_pkg::cfg_t  cfg,
  output lbcf_pkg::pins_t pins
);

  logic [1:0]               mode_r, mode_nxt;
  logic                     paused_r, paused_nxt;
  logic [lbcf_pkg::CNT_W-1:0] tick_r, tick_nxt;
  logic [lbcf_pkg::CNT_W-1:0] duty_r, duty_nxt;
  logic                     ramp_r, ramp_nxt;
  logic [1:0]               pair_r, pair_nxt;
  lbcf_pkg::pins_t          pins_r, pins_nxt;

  always_comb begin
    logic                       lvl_on;
    logic                       lvl_off;
    logic                       want_pause;
    logic                       from_lvl;
    logic                       to_lvl;
    logic                       wrapped;
    logic [lbcf_pkg::CNT_W-1:0] period_c;
    logic [lbcf_pkg::CNT_W-1:0] floor_c;

    mode_nxt   = mode_r;
    paused_nxt = paused_r;
    tick_nxt   = tick_r;
    duty_nxt   = duty_r;
    ramp_nxt   = ramp_r;
    pair_nxt   = pair_r;
    pins_nxt   = pins_r;
    lvl_on     = ~cfg.common_anode;
    lvl_off    = cfg.common_anode;
    want_pause = ~item.playing;
    period_c   = lbcf_pkg::CNT_W'(cfg.pwm_period);
    floor_c    = lbcf_pkg::CNT_W'(cfg.breath_floor);
    from_lvl   = 1'b0;
    to_lvl     = 1'b0;
    wrapped    = 1'b0;

    if (step) begin
      if (mode_r == item.requested_mode) begin
        case (mode_r)
          lbcf_pkg::MODE_BREATH: begin
            if (paused_r != want_pause) begin
              paused_nxt = want_pause;
              if (want_pause) begin
                pins_nxt.red   = lvl_on;
                pins_nxt.green = lvl_off;
              end else begin
                pins_nxt.red = lvl_off;
              end
            end
            if (!want_pause) begin
              tick_nxt = tick_r + 1'b1;
              if (tick_nxt == period_c) begin
                tick_nxt       = '0;
                pins_nxt.green = lvl_off;
                duty_nxt       = ramp_r ? duty_r + 1'b1 : duty_r - 1'b1;
                if (duty_nxt == period_c) begin
                  ramp_nxt = 1'b0;
                end else if (duty_nxt == floor_c) begin
                  ramp_nxt = 1'b1;
                end
              end
              if (tick_nxt == duty_nxt) begin
                pins_nxt.green = lvl_on;
              end
            end
          end
          lbcf_pkg::MODE_FADE: begin
            paused_nxt = want_pause;
            if (want_pause) begin
              pins_nxt.green = lvl_off;
              pins_nxt.blue  = lvl_off;
              pins_nxt.red   = lvl_on;
            end else if (pair_r != lbcf_pkg::PAIR_SPARE) begin
              case (pair_r)
                lbcf_pkg::PAIR_RG: begin from_lvl = pins_r.red;   to_lvl = pins_r.green; end
                lbcf_pkg::PAIR_GB: begin from_lvl = pins_r.green; to_lvl = pins_r.blue;  end
                default:           begin from_lvl = pins_r.blue;  to_lvl = pins_r.red;   end
              endcase
              tick_nxt = tick_r + 1'b1;
              if (tick_nxt == period_c) begin
                tick_nxt = '0;
                from_lvl = lvl_off;
                to_lvl   = lvl_on;
                duty_nxt = ramp_r ? duty_r + 1'b1 : duty_r - 1'b1;
                if (duty_nxt == period_c) begin
                  ramp_nxt = 1'b1;
                  duty_nxt = '0;
                  wrapped  = 1'b1;
                  pair_nxt = (pair_r == lbcf_pkg::PAIR_BR) ? lbcf_pkg::PAIR_RG
                                                           : pair_r + 1'b1;
                end else if (duty_nxt == lbcf_pkg::CNT_W'(1)) begin
                  ramp_nxt = 1'b1;
                end
              end
              if (!wrapped && tick_nxt == duty_nxt) begin
                from_lvl = lvl_on;
                to_lvl   = lvl_off;
              end
              case (pair_r)
                lbcf_pkg::PAIR_RG: begin pins_nxt.red   = from_lvl; pins_nxt.green = to_lvl; end
                lbcf_pkg::PAIR_GB: begin pins_nxt.green = from_lvl; pins_nxt.blue  = to_lvl; end
                default:           begin pins_nxt.blue  = from_lvl; pins_nxt.red   = to_lvl; end
              endcase
            end
          end
          default: ;
        endcase
      end else begin
        mode_nxt = item.requested_mode;
        case (item.requested_mode)
          lbcf_pkg::MODE_OFF: begin
            pins_nxt.power = ~cfg.common_anode;
            pins_nxt.red   = lvl_off;
            pins_nxt.green = lvl_off;
            pins_nxt.blue  = lvl_off;
          end
          lbcf_pkg::MODE_BREATH: begin
            tick_nxt       = '0;
            ramp_nxt       = 1'b1;
            duty_nxt       = '0;
            pins_nxt.power = cfg.common_anode;
            if (!item.playing) begin
              pins_nxt.green = lvl_off;
              pins_nxt.blue  = lvl_off;
              pins_nxt.red   = lvl_on;
            end
          end
          lbcf_pkg::MODE_FADE: begin
            pins_nxt.power = cfg.common_anode;
            tick_nxt       = '0;
            ramp_nxt       = 1'b1;
            duty_nxt       = '0;
            pair_nxt       = lbcf_pkg::PAIR_RG;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= lbcf_pkg::MODE_BREATH;
      paused_r <= 1'b1;
      tick_r   <= '0;
      duty_r   <= '0;
      ramp_r   <= 1'b1;
      pair_r   <= lbcf_pkg::PAIR_RG;
      pins_r   <= '{blue: lbcf_pkg::ANODE_RST, green: lbcf_pkg::ANODE_RST,
                    red: ~lbcf_pkg::ANODE_RST, power: lbcf_pkg::ANODE_RST};
    end else begin
      mode_r   <= mode_nxt;
      paused_r <= paused_nxt;
      tick_r   <= tick_nxt;
      duty_r   <= duty_nxt;
      ramp_r   <= ramp_nxt;
      pair_r   <= pair_nxt;
      pins_r   <= pins_nxt;
    end
  end

  assign pins = pins_r;

  `LBCF_ASSERT_NXT(a_off_entry_power, clk, rst_n,
    step && item.requested_mode == lbcf_pkg::MODE_OFF && mode_r != lbcf_pkg::MODE_OFF,
    pins_r.power == !$past(cfg.common_anode))
  `LBCF_ASSERT_NXT(a_idle_holds, clk, rst_n, !step,
    $stable(pins_r) && $stable(tick_r) && $stable(duty_r) && $stable(mode_r))
  `LBCF_ASSERT_NXT(a_entry_clears_tick, clk, rst_n,
    step && item.requested_mode != mode_r &&
    (item.requested_mode == lbcf_pkg::MODE_BREATH || item.requested_mode == lbcf_pkg::MODE_FADE),
    tick_r == '0 && duty_r == '0 && ramp_r)
  `LBCF_ASSERT_IMP(a_pair_valid, clk, rst_n, 1'b1, pair_r != lbcf_pkg::PAIR_SPARE)

endmodule

### hdl/led_breath_and_color_fade_pwm_unit.sv
// ----------------------------------------------------------------------------
// led_breath_and_color_fade_pwm_unit
// Software-style PWM for an RGB LED: off, green breathing and color fade.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one item per timer tick, carrying the requested mode
//   and the playing flag. Result channel out_*: the four pin levels after
//   that tick, one result per item.
//   Configuration port cfg_*: index 0 PWM period, 1 breathing floor,
//   2 common anode polarity; write only while no item is in flight.
//   Latency: a result is valid the cycle after its item is accepted.
//   Throughput: one item per cycle; the tick counter, duty compare and pin
//   update are a single compare/increment stage feeding the pin registers.
//   The pin registers are the result register. in_tready is high while the
//   result slot is empty or being taken, so a stalled receiver holds the
//   result and stops new items until out_tready returns.
//   Reset: breathing mode, paused (red lit), counters cleared, registers at
//   period 200, floor 75, common anode.
// ----------------------------------------------------------------------------
`include "led_breath_and_color_fade_pwm_unit_macros.svh"

module led_breath_and_color_fade_pwm_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [1:0] requested_mode, [2] playing
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] power_pin, [1] red_pin, [2] green_pin, [3] blue_pin
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  lbcf_pkg::cfg_t  cfg_r;
  lbcf_pkg::item_t item;
  lbcf_pkg::pins_t pins;
  logic            out_valid_r;
  logic            step;

  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;
  assign item      = '{requested_mode: in_tdata[1:0], playing: in_tdata[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pwm_period: lbcf_pkg::PERIOD_RST, breath_floor: lbcf_pkg::FLOOR_RST,
                 common_anode: lbcf_pkg::ANODE_RST};
    end else if (cfg_we) begin
      case (cfg_index)
        lbcf_pkg::CFG_PERIOD: cfg_r.pwm_period   <= cfg_wdata;
        lbcf_pkg::CFG_FLOOR:  cfg_r.breath_floor <= cfg_wdata;
        lbcf_pkg::CFG_ANODE:  cfg_r.common_anode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  lbcf_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .cfg   (cfg_r),
    .pins  (pins)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, pins.blue, pins.green, pins.red, pins.power};

  `LBCF_ASSERT_NXT(a_item_gives_result, clk, rst_n, step, out_tvalid)
  `LBCF_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid_r, in_tready)
  `LBCF_ASSERT_NXT(a_cfg_period_write, clk, rst_n,
    cfg_we && cfg_index == lbcf_pkg::CFG_PERIOD,
    cfg_r.pwm_period == $past(cfg_wdata))

endmodule

### tb/led_breath_and_color_fade_pwm_unit_test.sv
// ----------------------------------------------------------------------------
// led_breath_and_color_fade_pwm_unit_test
// Self-checking bench for the LED breathing / color fade PWM unit. Timer
// ticks go in as items with random idle bursts on both channels. A local
// model of the mode, duty and fade state predicts the four pin levels of
// every tick. Each returned item is compared pin by pin in arrival order.
// The run steps through several period, floor and polarity settings,
// including the extremes.
// ----------------------------------------------------------------------------
module led_breath_and_color_fade_pwm_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int         RED        = 0;
  localparam int         GREEN      = 1;
  localparam int         BLUE       = 2;
  localparam int         LIMIT      = 500000;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;   // [1:0] requested_mode, [2] playing
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [0] power_pin, [1] red_pin, [2] green_pin, [3] blue_pin
  logic       cfg_we     = 1'b0;
  logic [1:0] cfg_index  = '0;
  logic [7:0] cfg_wdata  = '0;

  led_breath_and_color_fade_pwm_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // LED controller state
  lbcf_pkg::cfg_t             regs;
  logic [1:0]                 cur_mode;
  logic                       hold_red;
  logic [lbcf_pkg::CNT_W-1:0] tick_cnt;
  logic [lbcf_pkg::CNT_W-1:0] duty;
  logic                       rising;
  logic [1:0]                 pair;
  logic                       power_lvl;
  logic [2:0]                 color_lvl;

  lbcf_pkg::item_t ticks_pending[$];
  lbcf_pkg::pins_t lamp_expect[$];
  int    fail_count    = 0;
  int    cycles        = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    send_gap      = 0;
  int    recv_gap      = 0;

  function automatic void breathe();
    tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt == regs.pwm_period) begin
      tick_cnt         = '0;
      color_lvl[GREEN] = regs.common_anode;
      duty             = rising ? duty + 1'b1 : duty - 1'b1;
      if (duty == regs.pwm_period) rising = 1'b0;
      else if (duty == regs.breath_floor) rising = 1'b1;
    end
    if (tick_cnt == duty) color_lvl[GREEN] = ~regs.common_anode;
  endfunction

  function automatic void fade();
    int src;
    int dst;
    if (pair == lbcf_pkg::PAIR_RG) begin
      src = RED;
      dst = GREEN;
    end else if (pair == lbcf_pkg::PAIR_GB) begin
      src = GREEN;
      dst = BLUE;
    end else if (pair == lbcf_pkg::PAIR_BR) begin
      src = BLUE;
      dst = RED;
    end else begin
      return;
    end
    tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt == regs.pwm_period) begin
      tick_cnt       = '0;
      color_lvl[src] = regs.common_anode;
      color_lvl[dst] = ~regs.common_anode;
      duty           = rising ? duty + 1'b1 : duty - 1'b1;
      if (duty == regs.pwm_period) begin
        rising = 1'b1;
        duty   = '0;
        pair   = (pair == lbcf_pkg::PAIR_BR) ? lbcf_pkg::PAIR_RG : pair + 1'b1;
        return;
      end else if (duty == 1) begin
        rising = 1'b1;
      end
    end
    if (tick_cnt == duty) begin
      color_lvl[src] = ~regs.common_anode;
      color_lvl[dst] = regs.common_anode;
    end
  endfunction

  function automatic lbcf_pkg::pins_t next_pins(lbcf_pkg::item_t t);
    lbcf_pkg::pins_t p;
    logic            want_pause;
    want_pause = ~t.playing;
    if (cur_mode == t.requested_mode) begin
      if (cur_mode == lbcf_pkg::MODE_BREATH) begin
        if (hold_red != want_pause) begin
          hold_red = want_pause;
          if (hold_red) begin
            color_lvl[RED]   = ~regs.common_anode;
            color_lvl[GREEN] = regs.common_anode;
          end else begin
            color_lvl[RED] = regs.common_anode;
          end
        end
        if (!hold_red) breathe();
      end else if (cur_mode == lbcf_pkg::MODE_FADE) begin
        hold_red = want_pause;
        if (!hold_red) begin
          fade();
        end else begin
          color_lvl[GREEN] = regs.common_anode;
          color_lvl[BLUE]  = regs.common_anode;
          color_lvl[RED]   = ~regs.common_anode;
        end
      end
    end else begin
      cur_mode = t.requested_mode;
      if (t.requested_mode == lbcf_pkg::MODE_OFF) begin
        power_lvl = ~regs.common_anode;
        color_lvl = {3{regs.common_anode}};
      end else if (t.requested_mode == lbcf_pkg::MODE_BREATH) begin
        tick_cnt  = '0;
        rising    = 1'b1;
        duty      = '0;
        power_lvl = regs.common_anode;
        if (!t.playing) begin
          color_lvl[GREEN] = regs.common_anode;
          color_lvl[BLUE]  = regs.common_anode;
          color_lvl[RED]   = ~regs.common_anode;
        end
      end else if (t.requested_mode == lbcf_pkg::MODE_FADE) begin
        power_lvl = regs.common_anode;
        tick_cnt  = '0;
        rising    = 1'b1;
        duty      = '0;
        pair      = lbcf_pkg::PAIR_RG;
      end
    end
    p.power = power_lvl;
    p.red   = color_lvl[RED];
    p.green = color_lvl[GREEN];
    p.blue  = color_lvl[BLUE];
    return p;
  endfunction

  // tick driver
  always @(posedge clk) begin : drive_ticks
    lbcf_pkg::item_t t;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        t.requested_mode = in_tdata[1:0];
        t.playing        = in_tdata[2];
        lamp_expect.push_back(next_pins(t));
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (ticks_pending.size() != 0) begin
          t = ticks_pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {5'b0, t.playing, t.requested_mode};
          if ($urandom_range(0, 99) < send_idle_pct) send_gap <= $urandom_range(1, 15);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // pin monitor
  always @(posedge clk) begin : check_pins
    lbcf_pkg::pins_t got;
    lbcf_pkg::pins_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap   <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = lbcf_pkg::pins_t'(out_tdata[3:0]);
        if (lamp_expect.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected item: pins %b", got);
        end else begin
          want = lamp_expect.pop_front();
          if (got.power !== want.power || got.red !== want.red ||
              got.green !== want.green || got.blue !== want.blue) begin
            fail_count++;
            if (fail_count <= 10)
              $display("pin mismatch %0t: exp pwr %b r %b g %b b %b, got pwr %b r %b g %b b %b",
                       $realtime, want.power, want.red, want.green, want.blue,
                       got.power, got.red, got.green, got.blue);
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap   <= recv_gap - 1;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap   <= $urandom_range(0, 14);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL led_breath_and_color_fade_pwm_unit");
      $finish;
    end
  end

  task automatic push_tick(input logic [1:0] mode, input logic playing);
    lbcf_pkg::item_t t;
    t.requested_mode = mode;
    t.playing        = playing;
    ticks_pending.push_back(t);
  endtask

  // runs of one mode, mostly playing, with some pauses and odd modes mixed in
  task automatic queue_runs(input int count, input int run_max);
    int         n;
    int         len;
    int         pick;
    logic [1:0] mode;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      mode = (pick < 40) ? lbcf_pkg::MODE_BREATH : (pick < 80) ? lbcf_pkg::MODE_FADE :
             (pick < 93) ? lbcf_pkg::MODE_OFF : MODE_SPARE;
      len  = $urandom_range(1, run_max);
      for (int i = 0; i < len && n < count; i++) begin
        push_tick(mode, $urandom_range(0, 19) != 0);
        n++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (ticks_pending.size() != 0 || in_tvalid || lamp_expect.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      lbcf_pkg::CFG_PERIOD: regs.pwm_period   = val;
      lbcf_pkg::CFG_FLOOR:  regs.breath_floor = val;
      lbcf_pkg::CFG_ANODE:  regs.common_anode = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] period, input logic [7:0] floor_lvl,
                           input logic anode, input int count, input int run_max,
                           input int send_pct, input int recv_pct);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(lbcf_pkg::CFG_PERIOD, period);
    write_reg(lbcf_pkg::CFG_FLOOR, floor_lvl);
    write_reg(lbcf_pkg::CFG_ANODE, {7'b0, anode});
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queue_runs(count / 2, run_max);
    wait_drained();
    queue_runs(count - count / 2, run_max);
  endtask

  initial begin
    logic [7:0] per;
    regs.pwm_period   = lbcf_pkg::PERIOD_RST;
    regs.breath_floor = lbcf_pkg::FLOOR_RST;
    regs.common_anode = lbcf_pkg::ANODE_RST;
    cur_mode  = lbcf_pkg::MODE_BREATH;
    hold_red  = 1'b1;
    tick_cnt  = '0;
    duty      = '0;
    rising    = 1'b1;
    pair      = lbcf_pkg::PAIR_RG;
    power_lvl = lbcf_pkg::ANODE_RST;
    color_lvl = {lbcf_pkg::ANODE_RST, lbcf_pkg::ANODE_RST, ~lbcf_pkg::ANODE_RST};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: pause handling, several mode changes, spare mode, both pause entries
    send_idle_pct = 20;
    recv_idle_pct = 5;
    push_tick(lbcf_pkg::MODE_BREATH, 1'b0);
    push_tick(lbcf_pkg::MODE_BREATH, 1'b1);
    push_tick(lbcf_pkg::MODE_BREATH, 1'b1);
    push_tick(lbcf_pkg::MODE_BREATH, 1'b1);
    push_tick(lbcf_pkg::MODE_BREATH, 1'b0);
    push_tick(lbcf_pkg::MODE_BREATH, 1'b1);
    push_tick(lbcf_pkg::MODE_FADE, 1'b1);
    push_tick(lbcf_pkg::MODE_FADE, 1'b1);
    push_tick(lbcf_pkg::MODE_FADE, 1'b0);
    push_tick(lbcf_pkg::MODE_FADE, 1'b1);
    push_tick(lbcf_pkg::MODE_OFF, 1'b0);
    push_tick(lbcf_pkg::MODE_OFF, 1'b1);
    push_tick(MODE_SPARE, 1'b1);
    push_tick(MODE_SPARE, 1'b0);
    push_tick(lbcf_pkg::MODE_BREATH, 1'b0);
    push_tick(lbcf_pkg::MODE_BREATH, 1'b0);
    push_tick(lbcf_pkg::MODE_FADE, 1'b0);
    push_tick(lbcf_pkg::MODE_FADE, 1'b0);
    push_tick(MODE_SPARE, 1'b0);
    push_tick(lbcf_pkg::MODE_OFF, 1'b0);
    push_tick(lbcf_pkg::MODE_BREATH, 1'b1);
    push_tick(lbcf_pkg::MODE_FADE, 1'b1);

    run_phase(8'd2, 8'd1, 1'b0, 170, 40, 10, 5);
    run_phase(8'd3, 8'd254, 1'b1, 170, 60, 30, 15);
    run_phase(8'd255, 8'd254, 1'b1, 600, 600, 0, 0);
    run_phase(8'd4, 8'd4, 1'b0, 170, 60, 10, 5);
    run_phase(8'd5, 8'd2, 1'b0, 170, 60, 30, 15);
    per = 8'($urandom_range(2, 12));
    run_phase(per, 8'($urandom_range(1, per - 1)), 1'($urandom_range(0, 1)),
              170, 60, 10, 5);
    per = 8'($urandom_range(2, 40));
    run_phase(per, 8'($urandom_range(1, 254)), 1'($urandom_range(0, 1)),
              170, 80, 30, 15);
    per = 8'($urandom_range(2, 10));
    run_phase(per, 8'($urandom_range(1, per - 1)), 1'($urandom_range(0, 1)),
              170, 60, 0, 0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && lamp_expect.size() == 0) begin
      $display("PASS led_breath_and_color_fade_pwm_unit");
    end else begin
      $display("FAIL led_breath_and_color_fade_pwm_unit");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/lbcf_pkg.sv
hdl/lbcf_core.sv
hdl/led_breath_and_color_fade_pwm_unit.sv
tb/led_breath_and_color_fade_pwm_unit_test.sv
